// ===== hw/rtl/csf_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Circular sample FIFO package
// Shared constants, mode codes and controller/datapath interface types.
// ============================================================================
package csf_pkg;

    localparam int CAPACITY_DEF  = 1023;
    localparam int MAX_BURST_DEF = 64;
    localparam int SAMPLE_W      = 32;
    localparam int COUNT_W       = 7;
    localparam int OFFSET_W      = 10;
    localparam int LEVEL_W       = 10;

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_PEEK  = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    typedef struct packed {
        logic write;
        logic clear;
        logic latch;
        logic latch_peek;
        logic setup;
        logic empty_res;
        logic issue;
        logic remove;
    } cmd_t;

    typedef struct packed {
        logic burst_empty;
        logic last_issue;
    } status_t;

endpackage

// ===== hw/rtl/csf_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Circular sample FIFO controller
// Sequences each item and issues commands to the datapath.
// ============================================================================
module csf_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         mode,
    input  csf_pkg::status_t   status,
    output csf_pkg::cmd_t      cmd,
    output logic               busy
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN
    } state_t;

    state_t state_reg;
    logic   remove_reg;
    logic   busy_reg;

    always_comb
    begin
        cmd        = '0;
        cmd.remove = remove_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (csf_pkg::mode_t'(mode))
                        csf_pkg::MODE_WRITE: cmd.write = 1'b1;
                        csf_pkg::MODE_CLEAR: cmd.clear = 1'b1;
                        csf_pkg::MODE_PEEK:
                        begin
                            cmd.latch      = 1'b1;
                            cmd.latch_peek = 1'b1;
                        end
                        default: cmd.latch = 1'b1;
                    endcase
                end
            end
            ST_SETUP:
            begin
                cmd.setup     = 1'b1;
                cmd.empty_res = status.burst_empty;
            end
            ST_RUN:
            begin
                cmd.issue = 1'b1;
            end
            default:
            begin
                cmd.remove = remove_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            remove_reg <= 1'b0;
            busy_reg   <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (start && (csf_pkg::mode_t'(mode) inside
                                  {csf_pkg::MODE_READ, csf_pkg::MODE_PEEK}))
                    begin
                        state_reg  <= ST_SETUP;
                        remove_reg <= (csf_pkg::mode_t'(mode) == csf_pkg::MODE_READ);
                        busy_reg   <= 1'b1;
                    end
                end
                ST_SETUP:
                begin
                    if (status.burst_empty)
                    begin
                        state_reg <= ST_IDLE;
                        busy_reg  <= 1'b0;
                    end
                    else
                    begin
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (status.last_issue)
                    begin
                        state_reg <= ST_IDLE;
                        busy_reg  <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    busy_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign busy = busy_reg;

endmodule

// ===== hw/rtl/csf_datapath.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Circular sample FIFO datapath
// Sample store, wrapping pointers, fill level and registered result port.
// ============================================================================
module csf_datapath #(
    parameter int CAPACITY  = csf_pkg::CAPACITY_DEF,
    parameter int MAX_BURST = csf_pkg::MAX_BURST_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [csf_pkg::SAMPLE_W-1:0]   sample_in,
    input  logic [csf_pkg::COUNT_W-1:0]    count,
    input  logic [csf_pkg::OFFSET_W-1:0]   peek_offset,
    input  csf_pkg::cmd_t                  cmd,
    output csf_pkg::status_t               status,
    output logic                           strobe,
    output logic [csf_pkg::SAMPLE_W-1:0]   sample_out,
    output logic                           valid_res,
    output logic                           last,
    output logic [csf_pkg::LEVEL_W-1:0]    fill_level,
    output logic [csf_pkg::LEVEL_W-1:0]    free_space
);

    localparam int SLOTS = CAPACITY + 1;
    localparam int PTR_W = $clog2(SLOTS);
    localparam int BW    = $clog2(MAX_BURST + 1);
    localparam int CW_A  = (PTR_W > csf_pkg::OFFSET_W) ? PTR_W : csf_pkg::OFFSET_W;
    localparam int CW    = (CW_A > csf_pkg::LEVEL_W) ? CW_A : csf_pkg::LEVEL_W;
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(CAPACITY);

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        wrap_inc = (p == LAST_SLOT) ? '0 : p + 1'b1;
    endfunction

    logic [csf_pkg::SAMPLE_W-1:0] mem [SLOTS];
    logic [csf_pkg::SAMPLE_W-1:0] rdata_reg;

    logic [PTR_W-1:0]            head_reg, head_next;
    logic [PTR_W-1:0]            tail_reg, tail_next;
    logic [PTR_W-1:0]            fill_reg, fill_next;
    logic [PTR_W-1:0]            pos_reg,  pos_next;
    logic [BW-1:0]               remain_reg, remain_next;
    logic [BW-1:0]               cnt_reg;
    logic [csf_pkg::OFFSET_W-1:0] offs_reg;

    logic                        strobe_reg, strobe_next;
    logic                        from_mem_reg, from_mem_next;
    logic                        valid_reg, valid_next;
    logic                        last_reg, last_next;
    logic [csf_pkg::LEVEL_W-1:0] level_reg, level_next;
    logic [csf_pkg::LEVEL_W-1:0] free_reg, free_next;

    logic [BW-1:0]    cnt_sat;
    logic [CW-1:0]    fill_w, offs_w, avail, level_ext, free_ext;
    logic [BW-1:0]    burst_n;
    logic [PTR_W:0]   start_sum;
    logic [PTR_W-1:0] start_pos;
    logic             full;

    always_comb
    begin
        cnt_sat   = (count > csf_pkg::COUNT_W'(MAX_BURST)) ? BW'(MAX_BURST) : BW'(count);
        fill_w    = CW'(fill_reg);
        offs_w    = CW'(offs_reg);
        avail     = fill_w - offs_w;
        burst_n   = (avail < CW'(cnt_reg)) ? BW'(avail) : cnt_reg;
        start_sum = {1'b0, head_reg} + (PTR_W + 1)'(offs_reg);
        start_pos = (start_sum >= (PTR_W + 1)'(SLOTS))
                  ? PTR_W'(start_sum - (PTR_W + 1)'(SLOTS)) : PTR_W'(start_sum);
        full      = (fill_reg == LAST_SLOT);

        status.burst_empty = (offs_w >= fill_w) || (cnt_reg == '0);
        status.last_issue  = (remain_reg == BW'(1));

        head_next     = head_reg;
        tail_next     = tail_reg;
        fill_next     = fill_reg;
        pos_next      = pos_reg;
        remain_next   = remain_reg;
        strobe_next   = 1'b0;
        from_mem_next = 1'b0;
        valid_next    = 1'b0;
        last_next     = 1'b1;

        if (cmd.write)
        begin
            strobe_next = 1'b1;
            valid_next  = !full;
            if (!full)
            begin
                tail_next = wrap_inc(tail_reg);
                fill_next = fill_reg + 1'b1;
            end
        end
        else if (cmd.clear)
        begin
            strobe_next = 1'b1;
            head_next   = '0;
            tail_next   = '0;
            fill_next   = '0;
        end
        else if (cmd.setup)
        begin
            strobe_next = cmd.empty_res;
            pos_next    = start_pos;
            remain_next = burst_n;
        end
        else if (cmd.issue)
        begin
            strobe_next   = 1'b1;
            from_mem_next = 1'b1;
            valid_next    = 1'b1;
            last_next     = (remain_reg == BW'(1));
            pos_next      = wrap_inc(pos_reg);
            remain_next   = remain_reg - 1'b1;
            if (cmd.remove)
            begin
                head_next = wrap_inc(pos_reg);
                fill_next = fill_reg - 1'b1;
            end
        end

        level_ext  = CW'(fill_next);
        free_ext   = CW'(CAPACITY) - level_ext;
        level_next = level_ext[csf_pkg::LEVEL_W-1:0];
        free_next  = free_ext[csf_pkg::LEVEL_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write && !full)
        begin
            mem[tail_reg] <= sample_in;
        end
        if (cmd.issue)
        begin
            rdata_reg <= mem[pos_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            tail_reg     <= '0;
            fill_reg     <= '0;
            strobe_reg   <= 1'b0;
            from_mem_reg <= 1'b0;
        end
        else
        begin
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            fill_reg     <= fill_next;
            strobe_reg   <= strobe_next;
            from_mem_reg <= from_mem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        remain_reg <= remain_next;
        valid_reg  <= valid_next;
        last_reg   <= last_next;
        level_reg  <= level_next;
        free_reg   <= free_next;
        if (cmd.latch)
        begin
            cnt_reg  <= cnt_sat;
            offs_reg <= cmd.latch_peek ? peek_offset : '0;
        end
    end

    assign strobe     = strobe_reg;
    assign sample_out = from_mem_reg ? rdata_reg : '0;
    assign valid_res  = valid_reg;
    assign last       = last_reg;
    assign fill_level = level_reg;
    assign free_space = free_reg;

endmodule

// ===== hw/rtl/circular_sample_fifo.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Circular sample FIFO
// Write and clear items are taken every cycle when idle; each result is registered
// and appears in the next cycle. A read or peek of n samples gives n results on
// consecutive cycles; the item is latched, a setup state sizes it, a run state issues
// it; busy holds to the last issue. With nothing available, setup gives one result.
// The single read port of the sample store sets the rate of one sample a cycle.
// Reset clears both pointers and the fill level; the store is not cleared.
// Results cannot be stalled by the receiver.
// ============================================================================
module circular_sample_fifo #(
    parameter int CAPACITY  = csf_pkg::CAPACITY_DEF,
    parameter int MAX_BURST = csf_pkg::MAX_BURST_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     mode,
    input  logic [csf_pkg::SAMPLE_W-1:0]   sample_in,
    input  logic [csf_pkg::COUNT_W-1:0]    count,
    input  logic [csf_pkg::OFFSET_W-1:0]   peek_offset,
    output logic                           strobe,
    output logic [csf_pkg::SAMPLE_W-1:0]   sample_out,
    output logic                           valid_res,
    output logic                           last,
    output logic [csf_pkg::LEVEL_W-1:0]    fill_level,
    output logic [csf_pkg::LEVEL_W-1:0]    free_space
);

    csf_pkg::cmd_t    cmd;
    csf_pkg::status_t status;

    csf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .mode   (mode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    csf_datapath #(
        .CAPACITY  (CAPACITY),
        .MAX_BURST (MAX_BURST)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_in   (sample_in),
        .count       (count),
        .peek_offset (peek_offset),
        .cmd         (cmd),
        .status      (status),
        .strobe      (strobe),
        .sample_out  (sample_out),
        .valid_res   (valid_res),
        .last        (last),
        .fill_level  (fill_level),
        .free_space  (free_space)
    );

    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (mode == csf_pkg::MODE_WRITE || mode == csf_pkg::MODE_CLEAR))
        |=> (strobe && last))
        else $error("write or clear item did not give a single result");

    a_level_sum: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (csf_pkg::LEVEL_W'(fill_level + free_space)
                    == csf_pkg::LEVEL_W'(CAPACITY)))
        else $error("fill level and free space do not add up to capacity");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !valid_res) |-> (last && sample_out == '0))
        else $error("invalid result is not a lone zero item");

    a_burst_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |-> busy)
        else $error("burst continues while the block is idle");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Circular sample FIFO testbench
// Drives write, read, peek and clear items with random gaps and checks every
// result strobe against a cycle-free model of the FIFO kept in the testbench.
// ============================================================================
module tb;

    localparam int CAP       = csf_pkg::CAPACITY_DEF;
    localparam int SLOTS     = CAP + 1;
    localparam int BURST_MAX = csf_pkg::MAX_BURST_DEF;

    typedef struct {
        csf_pkg::mode_t                mode;
        logic [csf_pkg::SAMPLE_W-1:0]  sample;
        logic [csf_pkg::COUNT_W-1:0]   cnt;
        logic [csf_pkg::OFFSET_W-1:0]  offs;
        int                            gap;
        bit                            drain;
    } stim_t;

    typedef struct {
        logic [csf_pkg::SAMPLE_W-1:0]  sample;
        logic                          valid;
        logic                          fin;
        logic [csf_pkg::LEVEL_W-1:0]   fill;
        logic [csf_pkg::LEVEL_W-1:0]   room;
    } report_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic [1:0]                    mode = csf_pkg::MODE_WRITE;
    logic [csf_pkg::SAMPLE_W-1:0]  sample_in = '0;
    logic [csf_pkg::COUNT_W-1:0]   count = '0;
    logic [csf_pkg::OFFSET_W-1:0]  peek_offset = '0;
    logic                          strobe;
    logic [csf_pkg::SAMPLE_W-1:0]  sample_out;
    logic                          valid_res;
    logic                          last;
    logic [csf_pkg::LEVEL_W-1:0]   fill_level;
    logic [csf_pkg::LEVEL_W-1:0]   free_space;

    stim_t                         item_q[$];
    report_t                       pending_reports[$];
    stim_t                         live_item;
    report_t                       want_rep;
    logic [csf_pkg::SAMPLE_W-1:0]  shadow_mem [0:SLOTS-1];
    int                            head_idx = 0;
    int                            tail_idx = 0;
    int                            pred_cnt = 0;
    int                            seen_cnt = 0;
    int                            wait_cnt = 0;
    int                            errors = 0;
    int                            plan_fill = 0;
    bit                            burst_mode = 1'b0;
    bit                            took;

    circular_sample_fifo i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .sample_in   (sample_in),
        .count       (count),
        .peek_offset (peek_offset),
        .strobe      (strobe),
        .sample_out  (sample_out),
        .valid_res   (valid_res),
        .last        (last),
        .fill_level  (fill_level),
        .free_space  (free_space)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int occupancy();
        if (tail_idx >= head_idx)
            return tail_idx - head_idx;
        return SLOTS - head_idx + tail_idx;
    endfunction

    function automatic int step_ptr(int p);
        return (p + 1 >= SLOTS) ? 0 : p + 1;
    endfunction

    function automatic void log_report(logic [csf_pkg::SAMPLE_W-1:0] s, logic v, logic f);
        report_t r;
        int      lvl;
        lvl      = occupancy();
        r.sample = s;
        r.valid  = v;
        r.fin    = f;
        r.fill   = csf_pkg::LEVEL_W'(lvl);
        r.room   = csf_pkg::LEVEL_W'(CAP - lvl);
        pending_reports.push_back(r);
    endfunction

    // Applies one item to the shadow FIFO and queues the reports it causes.
    function automatic int apply_fifo_item(stim_t it);
        int lvl;
        int n;
        int pos;
        int k;
        int want;
        lvl  = occupancy();
        want = (it.cnt > BURST_MAX) ? BURST_MAX : int'(it.cnt);
        case (it.mode)
            csf_pkg::MODE_WRITE:
            begin
                if (lvl >= CAP)
                begin
                    log_report('0, 1'b0, 1'b1);
                    return 1;
                end
                shadow_mem[tail_idx] = it.sample;
                tail_idx = step_ptr(tail_idx);
                log_report('0, 1'b1, 1'b1);
                return 1;
            end
            csf_pkg::MODE_CLEAR:
            begin
                head_idx = 0;
                tail_idx = 0;
                log_report('0, 1'b0, 1'b1);
                return 1;
            end
            csf_pkg::MODE_READ:
            begin
                n = (want < lvl) ? want : lvl;
                if (n == 0)
                begin
                    log_report('0, 1'b0, 1'b1);
                    return 1;
                end
                for (k = 0; k < n; k++)
                begin
                    pos = head_idx;
                    head_idx = step_ptr(head_idx);
                    log_report(shadow_mem[pos], 1'b1, k + 1 == n);
                end
                return n;
            end
            default:
            begin
                if (int'(it.offs) >= lvl || want == 0)
                begin
                    log_report('0, 1'b0, 1'b1);
                    return 1;
                end
                n = lvl - int'(it.offs);
                if (want < n)
                    n = want;
                pos = (head_idx + int'(it.offs)) % SLOTS;
                for (k = 0; k < n; k++)
                begin
                    log_report(shadow_mem[pos], 1'b1, k + 1 == n);
                    pos = step_ptr(pos);
                end
                return n;
            end
        endcase
    endfunction

    function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start       <= 1'b0;
            mode        <= csf_pkg::MODE_WRITE;
            sample_in   <= '0;
            count       <= '0;
            peek_offset <= '0;
            pred_cnt    <= 0;
            wait_cnt    <= 0;
        end
        else
        begin
            took = start && !busy;
            if (took)
                pred_cnt <= pred_cnt + apply_fifo_item(live_item);
            if (!start || took)
            begin
                if (item_q.size() == 0)
                    start <= 1'b0;
                else if (wait_cnt < item_q[0].gap)
                begin
                    wait_cnt <= wait_cnt + 1;
                    start    <= 1'b0;
                end
                else if (item_q[0].drain && (took || pred_cnt != seen_cnt))
                    start <= 1'b0;
                else
                begin
                    live_item = item_q.pop_front();
                    start       <= 1'b1;
                    mode        <= live_item.mode;
                    sample_in   <= live_item.sample;
                    count       <= live_item.cnt;
                    peek_offset <= live_item.offs;
                    wait_cnt    <= 0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_cnt <= 0;
        else if (strobe)
        begin
            seen_cnt <= seen_cnt + 1;
            if (seen_cnt >= pred_cnt)
            begin
                $display("%0t: result with nothing expected, actual sample %h valid %b",
                         $time, sample_out, valid_res);
                errors++;
            end
            else
            begin
                want_rep = pending_reports.pop_front();
                check_field("sample_out", want_rep.sample, sample_out);
                check_field("valid_res", 32'(want_rep.valid), 32'(valid_res));
                check_field("last", 32'(want_rep.fin), 32'(last));
                check_field("fill_level", 32'(want_rep.fill), 32'(fill_level));
                check_field("free_space", 32'(want_rep.room), 32'(free_space));
            end
        end
    end

    task automatic add_item(csf_pkg::mode_t m, logic [31:0] s, int c, int o, bit d);
        stim_t it;
        int    lim;
        it.mode   = m;
        it.sample = s;
        it.cnt    = csf_pkg::COUNT_W'(c);
        it.offs   = csf_pkg::OFFSET_W'(o);
        it.drain  = d;
        it.gap    = burst_mode ? 0 : $urandom_range(0, 13);
        lim = (c > BURST_MAX) ? BURST_MAX : c;
        case (m)
            csf_pkg::MODE_WRITE: if (plan_fill < CAP) plan_fill++;
            csf_pkg::MODE_READ:  plan_fill -= (lim < plan_fill) ? lim : plan_fill;
            csf_pkg::MODE_CLEAR: plan_fill = 0;
            default:    ;
        endcase
        item_q.push_back(it);
    endtask

    function automatic int pick_count();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 7)
            return $urandom_range(1, 8);
        if (roll < 9)
            return $urandom_range(9, BURST_MAX);
        return $urandom_range(0, 127);
    endfunction

    task automatic random_mix(int n);
        int i;
        int roll;
        bit hold;
        for (i = 0; i < n; i++)
        begin
            if (i % 40 == 0)
                burst_mode = ($urandom_range(0, 2) == 0);
            roll = $urandom_range(0, 99);
            hold = (i % 50 == 49);
            if (roll < 45)
                add_item(csf_pkg::MODE_WRITE, $urandom, $urandom_range(0, 127),
                         $urandom_range(0, 1023), hold);
            else if (roll < 68)
                add_item(csf_pkg::MODE_READ, $urandom, pick_count(),
                         $urandom_range(0, 1023), hold);
            else if (roll < 97)
                add_item(csf_pkg::MODE_PEEK, $urandom, pick_count(),
                         ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
                                                     : $urandom_range(0, plan_fill + 2),
                         hold);
            else
                add_item(csf_pkg::MODE_CLEAR, $urandom, $urandom_range(0, 127),
                         $urandom_range(0, 1023), hold);
        end
        burst_mode = 1'b0;
    endtask

    initial
    begin
        add_item(csf_pkg::MODE_READ, 32'h0, 1, 0, 1'b0);
        add_item(csf_pkg::MODE_PEEK, 32'hFFFF_FFFF, 1, 0, 1'b0);
        add_item(csf_pkg::MODE_WRITE, 32'h0000_0000, 0, 0, 1'b0);
        add_item(csf_pkg::MODE_WRITE, 32'hFFFF_FFFF, 127, 1023, 1'b0);
        add_item(csf_pkg::MODE_WRITE, 32'hA5A5_5A5A, 1, 0, 1'b0);
        add_item(csf_pkg::MODE_WRITE, 32'h5A5A_A5A5, 1, 0, 1'b0);
        add_item(csf_pkg::MODE_WRITE, 32'h8000_0001, 1, 0, 1'b0);
        add_item(csf_pkg::MODE_PEEK, 32'h0, 0, 0, 1'b0);
        add_item(csf_pkg::MODE_PEEK, 32'h0, 127, 0, 1'b0);
        add_item(csf_pkg::MODE_PEEK, 32'h0, 1, 4, 1'b0);
        add_item(csf_pkg::MODE_PEEK, 32'h0, 64, 5, 1'b0);
        add_item(csf_pkg::MODE_PEEK, 32'h0, 64, 1023, 1'b0);
        add_item(csf_pkg::MODE_READ, 32'h0, 0, 0, 1'b0);
        add_item(csf_pkg::MODE_READ, 32'h0, 2, 0, 1'b0);
        add_item(csf_pkg::MODE_READ, 32'h0, 127, 0, 1'b0);
        add_item(csf_pkg::MODE_READ, 32'h0, 64, 0, 1'b0);
        add_item(csf_pkg::MODE_CLEAR, 32'h0, 1, 0, 1'b0);
        add_item(csf_pkg::MODE_WRITE, 32'h1234_5678, 1, 0, 1'b0);
        add_item(csf_pkg::MODE_WRITE, 32'h0F0F_F0F0, 1, 0, 1'b0);
        add_item(csf_pkg::MODE_CLEAR, 32'hFFFF_FFFF, 127, 1023, 1'b1);
        add_item(csf_pkg::MODE_READ, 32'h0, 1, 0, 1'b0);
        add_item(csf_pkg::MODE_PEEK, 32'h0, 1, 0, 1'b0);
        random_mix(140);
        random_mix(140);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        while (item_q.size() != 0 || start)
            @(negedge clk);
        while (pred_cnt != seen_cnt)
            @(negedge clk);
        repeat (80) @(negedge clk);
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("tb: done, errors");
        $finish;
    end

endmodule
